>>> rtl/thc_pkg.sv
`timescale 1ns / 1ps

package thc_pkg;

  // Record header constants.
  localparam logic [7:0] CONTENT_HANDSHAKE = 8'h16;
  localparam logic [7:0] VERSION_MAJOR     = 8'h03;
  localparam logic [7:0] MINOR_LOW         = 8'h01;
  localparam logic [7:0] MINOR_HIGH        = 8'h03;

  // Handshake message kinds that the parser knows.
  localparam logic [7:0] KIND_CLIENT_HELLO = 8'd1;
  localparam logic [7:0] KIND_SERVER_HELLO = 8'd2;
  localparam logic [7:0] KIND_CERTIFICATE  = 8'd11;
  localparam logic [7:0] KIND_HELLO_DONE   = 8'd14;

  // Byte counter limits: header length, and the position from which a record is overlong.
  localparam int unsigned POS_WIDTH = 17;
  localparam logic [POS_WIDTH-1:0] HEADER_BYTES = 17'd9;
  localparam logic [POS_WIDTH-1:0] COUNT_LIMIT  = 17'd65540;
  localparam logic [15:0]          RANDOM_BYTES = 16'd32;

  // Result status codes.
  localparam logic [2:0] STATUS_OK          = 3'd0;
  localparam logic [2:0] STATUS_BAD_TYPE    = 3'd1;
  localparam logic [2:0] STATUS_BAD_VERSION = 3'd2;
  localparam logic [2:0] STATUS_BAD_LENGTH  = 3'd3;
  localparam logic [2:0] STATUS_TOO_SHORT   = 3'd4;
  localparam logic [2:0] STATUS_UNSUPPORTED = 3'd5;

  // One input word as held in the input register.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } thc_byte_t;

  // One result word.
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  record_minor;
    logic [7:0]  handshake_kind;
    logic [23:0] body_length;
    logic [7:0]  hello_minor;
    logic [7:0]  session_id_length;
    logic [15:0] suite_list_length;
    logic [15:0] chosen_suite;
    logic [7:0]  compression_length;
    logic [15:0] extension_length;
  } thc_result_t;

endpackage

>>> rtl/thc_in_reg.sv
`timescale 1ns / 1ps

module thc_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              data_valid,
  output logic              data_stall,
  input  logic [7:0]        data_byte,
  input  logic              last,
  input  logic              advance,
  output logic              word_valid,
  output thc_pkg::thc_byte_t word
);

  // The held word stalls the input only when the parser cannot take it.
  assign data_stall = word_valid && !advance;

  // Valid flag of the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (!data_stall) begin
      word_valid <= data_valid;
    end
  end

  // Payload of the input register.
  always_ff @(posedge clk) begin
    if (data_valid && !data_stall) begin
      word.data <= data_byte;
      word.last <= last;
    end
  end

endmodule

>>> rtl/thc_parser.sv
`timescale 1ns / 1ps

module thc_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  thc_pkg::thc_byte_t   word,
  output thc_pkg::thc_result_t result
);

  // Hello body field sequencer.
  typedef enum logic [13:0] {
    PH_VER_MAJ    = 14'b00000000000001,
    PH_VER_MIN    = 14'b00000000000010,
    PH_RANDOM     = 14'b00000000000100,
    PH_SESS_LEN   = 14'b00000000001000,
    PH_SESS_SKIP  = 14'b00000000010000,
    PH_SUITE_HI   = 14'b00000000100000,
    PH_SUITE_LO   = 14'b00000001000000,
    PH_SUITE_SKIP = 14'b00000010000000,
    PH_COMP_LEN   = 14'b00000100000000,
    PH_COMP_SKIP  = 14'b00001000000000,
    PH_EXT_HI     = 14'b00010000000000,
    PH_EXT_LO     = 14'b00100000000000,
    PH_DONE       = 14'b01000000000000,
    PH_SRV_COMP   = 14'b10000000000000
  } phase_t;

  logic [thc_pkg::POS_WIDTH-1:0] byte_position, byte_position_next, pos_upd, pos_off;
  logic [15:0] record_len, record_len_next, record_len_upd;
  logic [23:0] body_len, body_len_next, body_len_upd;
  logic [7:0]  hs_kind, hs_kind_next, hs_kind_upd;
  logic [2:0]  first_error, first_error_next, first_error_upd, err;
  logic [7:0]  rec_minor, rec_minor_next, rec_minor_upd;
  logic [7:0]  hello_ver_minor, hello_ver_minor_next, hello_ver_minor_upd;
  phase_t      hello_phase, hello_phase_next, hello_phase_upd;
  logic [15:0] skip_left, skip_left_next, skip_left_upd, skip_dec;
  logic [7:0]  sess_len, sess_len_next, sess_len_upd;
  logic [15:0] suite_len, suite_len_next, suite_len_upd;
  logic [15:0] suite_code, suite_code_next, suite_code_upd;
  logic [7:0]  comp_len, comp_len_next, comp_len_upd;
  logic [15:0] ext_len, ext_len_next, ext_len_upd;
  logic [23:0] body_full;
  logic [15:0] suite_full;
  logic [2:0]  status;
  logic        is_client, is_server, is_hello, minor_ok, skip_done;

  assign is_client = (hs_kind == thc_pkg::KIND_CLIENT_HELLO);
  assign is_server = (hs_kind == thc_pkg::KIND_SERVER_HELLO);
  assign is_hello  = is_client || is_server;
  assign minor_ok  = (word.data >= thc_pkg::MINOR_LOW) && (word.data <= thc_pkg::MINOR_HIGH);
  assign pos_off   = byte_position - thc_pkg::HEADER_BYTES;
  assign body_full = {body_len[23:8], word.data};
  assign suite_full = {suite_len[15:8], word.data};

  // Countdown used by every skip phase.
  assign skip_dec  = (skip_left != 16'd0) ? (skip_left - 16'd1) : skip_left;
  assign skip_done = (skip_dec == 16'd0);

  // Per-byte field decode and error detection.
  always_comb begin
    err                 = thc_pkg::STATUS_OK;
    record_len_upd      = record_len;
    body_len_upd        = body_len;
    hs_kind_upd         = hs_kind;
    rec_minor_upd       = rec_minor;
    hello_ver_minor_upd = hello_ver_minor;
    hello_phase_upd     = hello_phase;
    skip_left_upd       = skip_left;
    sess_len_upd        = sess_len;
    suite_len_upd       = suite_len;
    suite_code_upd      = suite_code;
    comp_len_upd        = comp_len;
    ext_len_upd         = ext_len;

    if (byte_position >= thc_pkg::COUNT_LIMIT) begin
      err = thc_pkg::STATUS_BAD_LENGTH;
    end else if (byte_position < thc_pkg::HEADER_BYTES) begin
      unique case (byte_position[3:0])
        4'd0: begin
          if (word.data != thc_pkg::CONTENT_HANDSHAKE) err = thc_pkg::STATUS_BAD_TYPE;
        end
        4'd1: begin
          if (word.data != thc_pkg::VERSION_MAJOR) err = thc_pkg::STATUS_BAD_VERSION;
        end
        4'd2: begin
          rec_minor_upd = word.data;
          if (!minor_ok) err = thc_pkg::STATUS_BAD_VERSION;
        end
        4'd3: record_len_upd = {word.data, 8'd0};
        4'd4: record_len_upd = {record_len[15:8], word.data};
        4'd5: hs_kind_upd = word.data;
        4'd6: body_len_upd = {word.data, 16'd0};
        4'd7: body_len_upd = {body_len[23:16], word.data, 8'd0};
        4'd8: begin
          body_len_upd = body_full;
          // Length check first, then the kind, then the empty-body rules.
          if ({9'd0, record_len} != ({1'b0, body_full} + 25'd4)) begin
            err = thc_pkg::STATUS_BAD_LENGTH;
          end else if (!is_hello && hs_kind != thc_pkg::KIND_CERTIFICATE &&
                       hs_kind != thc_pkg::KIND_HELLO_DONE) begin
            err = thc_pkg::STATUS_UNSUPPORTED;
          end else if ((hs_kind == thc_pkg::KIND_CERTIFICATE && body_full == 24'd0) ||
                       (hs_kind == thc_pkg::KIND_HELLO_DONE && body_full != 24'd0)) begin
            err = thc_pkg::STATUS_BAD_LENGTH;
          end
        end
        default: ;
      endcase
    end else if ({7'd0, pos_off} < body_len && is_hello) begin
      // Hello body bytes inside the stated body length.
      unique case (hello_phase)
        PH_VER_MAJ: begin
          if (word.data != thc_pkg::VERSION_MAJOR) err = thc_pkg::STATUS_BAD_VERSION;
          hello_phase_upd = PH_VER_MIN;
        end
        PH_VER_MIN: begin
          hello_ver_minor_upd = word.data;
          if (!minor_ok) err = thc_pkg::STATUS_BAD_VERSION;
          skip_left_upd   = thc_pkg::RANDOM_BYTES;
          hello_phase_upd = PH_RANDOM;
        end
        PH_RANDOM: begin
          skip_left_upd = skip_dec;
          if (skip_done) hello_phase_upd = PH_SESS_LEN;
        end
        PH_SESS_LEN: begin
          sess_len_upd    = word.data;
          skip_left_upd   = {8'd0, word.data};
          hello_phase_upd = (word.data == 8'd0) ? PH_SUITE_HI : PH_SESS_SKIP;
        end
        PH_SESS_SKIP: begin
          skip_left_upd = skip_dec;
          if (skip_done) hello_phase_upd = PH_SUITE_HI;
        end
        PH_SUITE_HI: begin
          if (is_client) suite_len_upd = {word.data, 8'd0};
          else suite_code_upd = {word.data, 8'd0};
          hello_phase_upd = PH_SUITE_LO;
        end
        PH_SUITE_LO: begin
          if (is_client) begin
            suite_len_upd   = suite_full;
            skip_left_upd   = suite_full;
            hello_phase_upd = (suite_full == 16'd0) ? PH_COMP_LEN : PH_SUITE_SKIP;
          end else begin
            suite_code_upd  = {suite_code[15:8], word.data};
            hello_phase_upd = PH_SRV_COMP;
          end
        end
        PH_SUITE_SKIP: begin
          skip_left_upd = skip_dec;
          if (skip_done) hello_phase_upd = PH_COMP_LEN;
        end
        PH_COMP_LEN: begin
          comp_len_upd    = word.data;
          skip_left_upd   = {8'd0, word.data};
          hello_phase_upd = (word.data == 8'd0) ? PH_EXT_HI : PH_COMP_SKIP;
        end
        PH_COMP_SKIP: begin
          skip_left_upd = skip_dec;
          if (skip_done) hello_phase_upd = PH_EXT_HI;
        end
        PH_SRV_COMP: hello_phase_upd = PH_EXT_HI;
        PH_EXT_HI: begin
          ext_len_upd     = {word.data, 8'd0};
          hello_phase_upd = PH_EXT_LO;
        end
        PH_EXT_LO: begin
          ext_len_upd     = {ext_len[15:8], word.data};
          hello_phase_upd = PH_DONE;
        end
        default: ;
      endcase
    end
  end

  // Keep only the first error; saturate the byte counter.
  assign first_error_upd = (first_error == thc_pkg::STATUS_OK) ? err : first_error;
  assign pos_upd = (byte_position <= thc_pkg::COUNT_LIMIT) ?
                   (byte_position + 17'd1) : byte_position;

  // Final status for the record, decided on its last byte.
  always_comb begin
    if (pos_upd <= 17'd4) begin
      status = thc_pkg::STATUS_TOO_SHORT;
    end else if (first_error_upd != thc_pkg::STATUS_OK) begin
      status = first_error_upd;
    end else if (pos_upd < thc_pkg::HEADER_BYTES) begin
      status = thc_pkg::STATUS_TOO_SHORT;
    end else if (pos_upd != ({1'b0, record_len_upd} + 17'd5)) begin
      status = thc_pkg::STATUS_BAD_LENGTH;
    end else begin
      status = thc_pkg::STATUS_OK;
    end
  end

  // Result word, built from the state that includes the last byte.
  always_comb begin
    result.status             = status;
    result.record_minor       = rec_minor_upd;
    result.handshake_kind     = hs_kind_upd;
    result.body_length        = body_len_upd;
    result.hello_minor        = is_hello ? hello_ver_minor_upd : 8'd0;
    result.session_id_length  = is_hello ? sess_len_upd : 8'd0;
    result.suite_list_length  = is_client ? suite_len_upd : 16'd0;
    result.chosen_suite       = is_server ? suite_code_upd : 16'd0;
    result.compression_length = is_client ? comp_len_upd : 8'd0;
    result.extension_length   = is_hello ? ext_len_upd : 16'd0;
  end

  // The last byte of a record returns the parser to its start state.
  always_comb begin
    if (word.last) begin
      byte_position_next   = '0;
      record_len_next      = '0;
      body_len_next        = '0;
      hs_kind_next         = '0;
      first_error_next     = thc_pkg::STATUS_OK;
      rec_minor_next       = '0;
      hello_ver_minor_next = '0;
      hello_phase_next     = PH_VER_MAJ;
      skip_left_next       = '0;
      sess_len_next        = '0;
      suite_len_next       = '0;
      suite_code_next      = '0;
      comp_len_next        = '0;
      ext_len_next         = '0;
    end else begin
      byte_position_next   = pos_upd;
      record_len_next      = record_len_upd;
      body_len_next        = body_len_upd;
      hs_kind_next         = hs_kind_upd;
      first_error_next     = first_error_upd;
      rec_minor_next       = rec_minor_upd;
      hello_ver_minor_next = hello_ver_minor_upd;
      hello_phase_next     = hello_phase_upd;
      skip_left_next       = skip_left_upd;
      sess_len_next        = sess_len_upd;
      suite_len_next       = suite_len_upd;
      suite_code_next      = suite_code_upd;
      comp_len_next        = comp_len_upd;
      ext_len_next         = ext_len_upd;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      record_len      <= '0;
      body_len        <= '0;
      hs_kind         <= '0;
      first_error     <= thc_pkg::STATUS_OK;
      rec_minor       <= '0;
      hello_ver_minor <= '0;
      hello_phase     <= PH_VER_MAJ;
      skip_left       <= '0;
      sess_len        <= '0;
      suite_len       <= '0;
      suite_code      <= '0;
      comp_len        <= '0;
      ext_len         <= '0;
    end else if (advance) begin
      byte_position   <= byte_position_next;
      record_len      <= record_len_next;
      body_len        <= body_len_next;
      hs_kind         <= hs_kind_next;
      first_error     <= first_error_next;
      rec_minor       <= rec_minor_next;
      hello_ver_minor <= hello_ver_minor_next;
      hello_phase     <= hello_phase_next;
      skip_left       <= skip_left_next;
      sess_len        <= sess_len_next;
      suite_len       <= suite_len_next;
      suite_code      <= suite_code_next;
      comp_len        <= comp_len_next;
      ext_len         <= ext_len_next;
    end
  end

  // The byte counter saturates one past the overlong limit.
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= (thc_pkg::COUNT_LIMIT + 17'd1))
    else $error("byte counter ran past its saturation value");

  // A processed last byte leaves the parser at the start of a record.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && word.last) |=> (byte_position == '0 && first_error == thc_pkg::STATUS_OK &&
                                hello_phase == PH_VER_MAJ))
    else $error("parser state not cleared after the last byte");

  // A kept error is never replaced within a record.
  a_error_kept: assert property (@(posedge clk) disable iff (rst)
    (first_error != thc_pkg::STATUS_OK && !(advance && word.last)) |=>
      (first_error == $past(first_error)))
    else $error("first error changed before the end of the record");

  // A nonzero skip count is only left over in a skip phase.
  a_skip_phase: assert property (@(posedge clk) disable iff (rst)
    (skip_left != 16'd0) |-> (hello_phase == PH_RANDOM || hello_phase == PH_SESS_SKIP ||
                              hello_phase == PH_SUITE_SKIP || hello_phase == PH_COMP_SKIP))
    else $error("skip count left over outside a skip phase");

endmodule

>>> rtl/thc_out_reg.sv
`timescale 1ns / 1ps

module thc_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  thc_pkg::thc_result_t result,
  output logic                 free,
  output logic                 result_valid,
  input  logic                 result_stall,
  output thc_pkg::thc_result_t held
);

  // The register can take a new word when empty or when its word leaves now.
  assign free = !result_valid || !result_stall;

  // Valid flag of the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (free) begin
      result_valid <= load;
    end
  end

  // Payload of the result register.
  always_ff @(posedge clk) begin
    if (load && free) begin
      held <= result;
    end
  end

endmodule

>>> rtl/tls_handshake_header_checker.sv
// TLS handshake record checker. Bytes of one record enter one per word on the data
// channel, with last set on the final byte; exactly one result word leaves per record,
// with the first error or an end length fault (or ok) and the header and hello fields.
// A byte is held in the input register and then passes through the parser; for a last
// byte the result is loaded into the result register. A new byte is accepted every
// cycle; only a last byte waits, when the result register is still held by a stall.
`timescale 1ns / 1ps

module tls_handshake_header_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  status,
  output logic [7:0]  record_minor,
  output logic [7:0]  handshake_kind,
  output logic [23:0] body_length,
  output logic [7:0]  hello_minor,
  output logic [7:0]  session_id_length,
  output logic [15:0] suite_list_length,
  output logic [15:0] chosen_suite,
  output logic [7:0]  compression_length,
  output logic [15:0] extension_length
);

  logic                 word_valid;
  thc_pkg::thc_byte_t   word;
  thc_pkg::thc_result_t result;
  thc_pkg::thc_result_t held;
  logic                 free;
  logic                 advance;

  // A byte moves through the parser unless it ends a record and the result is blocked.
  assign advance = word_valid && (!word.last || free);

  thc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data_byte  (data_byte),
    .last       (last),
    .advance    (advance),
    .word_valid (word_valid),
    .word       (word)
  );

  thc_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .word    (word),
    .result  (result)
  );

  thc_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && word.last),
    .result       (result),
    .free         (free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .held         (held)
  );

  // Result fields.
  assign status             = held.status;
  assign record_minor       = held.record_minor;
  assign handshake_kind     = held.handshake_kind;
  assign body_length        = held.body_length;
  assign hello_minor        = held.hello_minor;
  assign session_id_length  = held.session_id_length;
  assign suite_list_length  = held.suite_list_length;
  assign chosen_suite       = held.chosen_suite;
  assign compression_length = held.compression_length;
  assign extension_length   = held.extension_length;

endmodule
